FILE: sv/sem_pkg.sv
// Shared constants for the Sobel edge magnitude block.
// Used by the channel interfaces, the square-root unit and the top level.
// No dependencies.
`default_nettype none

package sem_pkg;

   // payload widths
   localparam int PIX_W  = 8;
   localparam int SQ_W   = 2 * PIX_W + 1;
   localparam int ROOT_STEPS = PIX_W;

   // frame geometry
   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int MIN_DIM           = 3;
   localparam int HEIGHT_LIMIT      = 4096;
   localparam int ROW_W             = 12;
   localparam int WIDTH_REG_W       = 11;
   localparam int HEIGHT_REG_W      = 13;

   // register reset values
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = HEIGHT_REG_W;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

endpackage

`default_nettype wire

FILE: sv/sem_if.sv
// Valid/ready channel interfaces for pixel requests and edge results.
// Depends on sem_pkg for payload widths.
`default_nettype none

interface sem_req_if;
   logic                      valid;
   logic                      ready;
   logic [sem_pkg::PIX_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface sem_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [sem_pkg::PIX_W-1:0] x_edge;
   logic [sem_pkg::PIX_W-1:0] y_edge;
   logic [sem_pkg::PIX_W-1:0] magnitude;
   logic                      frame_last;

   modport source (output valid, output x_edge, output y_edge, output magnitude,
                   output frame_last, input ready);
   modport sink   (input valid, input x_edge, input y_edge, input magnitude,
                   input frame_last, output ready);
endinterface

`default_nettype wire

FILE: sv/sobel_edge_magnitude.sv
// Sobel edge magnitude top level: line stores, 3x3 window, kernel sums, output register.
// Depends on sem_pkg, sem_req_if/sem_rsp_if and sem_isqrt.
//
// Takes 8-bit grey pixels in raster order and returns, for each interior pixel,
// the clamped x and y Sobel sums and their saturated root-sum-of-squares magnitude;
// border pixels produce no result, and frame_last marks the frame's final result.
// The two rows above live in two single-port line stores with a registered
// read; each pixel reads its column, then writes it back on the next cycle.
// A pixel that yields no result then returns to idle; one that yields a result
// goes on through the squaring stage and the bit-per-cycle square root (8 steps).
// The result sits in an output register, so the next pixel is taken while a
// result waits. Width and height are held in csr registers (index 0 and 1) and
// should be written only while the block is idle; the frame position is not
// reset by a write.
`default_nettype none

module sobel_edge_magnitude #(
   parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   sem_req_if.sink                              req_bus,
   sem_rsp_if.source                            rsp_bus,
   input  wire logic                            csr_we,
   input  wire logic [sem_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [sem_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CW_W   = (ADDR_W + 1 > sem_pkg::WIDTH_REG_W) ? ADDR_W + 1
                                                               : sem_pkg::WIDTH_REG_W;
   localparam int PW     = sem_pkg::PIX_W;
   localparam int KS_W   = PW + 2;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_READ   = 5'b00010,
      ST_SQUARE = 5'b00100,
      ST_START  = 5'b01000,
      ST_ROOT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [sem_pkg::WIDTH_REG_W-1:0]  width_ff;
   logic [sem_pkg::HEIGHT_REG_W-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sem_pkg::WIDTH_RESET;
         height_ff <= sem_pkg::HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            sem_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[sem_pkg::WIDTH_REG_W-1:0];
            sem_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective geometry, clamped to the legal range
   logic [CW_W-1:0]                  eff_w, width_ext;
   logic [sem_pkg::HEIGHT_REG_W-1:0] eff_h;

   always_comb begin
      width_ext = CW_W'(width_ff);
      if (width_ext < CW_W'(sem_pkg::MIN_DIM))  eff_w = CW_W'(sem_pkg::MIN_DIM);
      else if (width_ext > CW_W'(MAX_WIDTH))    eff_w = CW_W'(MAX_WIDTH);
      else                                      eff_w = width_ext;

      if (height_ff < sem_pkg::HEIGHT_REG_W'(sem_pkg::MIN_DIM))
         eff_h = sem_pkg::HEIGHT_REG_W'(sem_pkg::MIN_DIM);
      else if (height_ff > sem_pkg::HEIGHT_REG_W'(sem_pkg::HEIGHT_LIMIT))
         eff_h = sem_pkg::HEIGHT_REG_W'(sem_pkg::HEIGHT_LIMIT);
      else
         eff_h = height_ff;
   end

   // frame position and the accepted pixel
   logic [ADDR_W-1:0]        col_ff;
   logic [sem_pkg::ROW_W-1:0] row_ff;
   logic [PW-1:0]            pix_ff;
   logic                     req_fire;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (req_fire) pix_ff <= req_bus.pixel;
   end

   // line stores: a holds the row above, b the row two above
   logic [PW-1:0] row_a_mem [MAX_WIDTH];
   logic [PW-1:0] row_b_mem [MAX_WIDTH];
   logic [PW-1:0] mid_q, top_q;

   // read on accept; write back in the next cycle, before any later read
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mid_q <= row_a_mem[col_ff];
         top_q <= row_b_mem[col_ff];
      end
      if (state_ff == ST_READ) begin
         row_a_mem[col_ff] <= pix_ff;
         row_b_mem[col_ff] <= mid_q;
      end
   end

   // window: two earlier columns, top to bottom
   logic [PW-1:0] win_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else if (state_ff == ST_READ) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top_q;
         win_ff[4] <= mid_q;
         win_ff[5] <= pix_ff;
      end
   end

   // kernel sums
   function automatic logic [PW-1:0] clamp_sum(input logic signed [KS_W:0] s);
      logic [PW-1:0] res;
      if (s[KS_W])                 res = '0;
      else if (s[KS_W-1:PW] != '0) res = sem_pkg::PIX_MAX;
      else                         res = s[PW-1:0];
      return res;
   endfunction

   logic [KS_W-1:0]        left_sum, right_sum, bot_sum, top_sum;
   logic signed [KS_W:0]   sx, sy;
   logic [PW-1:0]          xe, ye;
   logic                   interior, last_pix, col_wrap, row_wrap;

   always_comb begin
      left_sum  = KS_W'(win_ff[0]) + {(KS_W-1)'(win_ff[1]), 1'b0} + KS_W'(win_ff[2]);
      right_sum = KS_W'(top_q) + {(KS_W-1)'(mid_q), 1'b0} + KS_W'(pix_ff);
      bot_sum   = KS_W'(win_ff[2]) + {(KS_W-1)'(win_ff[5]), 1'b0} + KS_W'(pix_ff);
      top_sum   = KS_W'(win_ff[0]) + {(KS_W-1)'(win_ff[3]), 1'b0} + KS_W'(top_q);
      sx = $signed({1'b0, left_sum}) - $signed({1'b0, right_sum});
      sy = $signed({1'b0, bot_sum})  - $signed({1'b0, top_sum});
      xe = clamp_sum(sx);
      ye = clamp_sum(sy);

      interior = (row_ff >= sem_pkg::ROW_W'(2)) && (col_ff >= ADDR_W'(2));
      last_pix = ({1'b0, row_ff} == eff_h - sem_pkg::HEIGHT_REG_W'(1))
              && (CW_W'(col_ff) == eff_w - CW_W'(1));
      col_wrap = (CW_W'(col_ff) + CW_W'(1)) >= eff_w;
      row_wrap = ({1'b0, row_ff} + sem_pkg::HEIGHT_REG_W'(1)) >= eff_h;
   end

   // advance the frame position once the pixel is written back
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (state_ff == ST_READ) begin
         if (col_wrap) begin
            col_ff <= '0;
            row_ff <= row_wrap ? '0 : row_ff + sem_pkg::ROW_W'(1);
         end else begin
            col_ff <= col_ff + ADDR_W'(1);
         end
      end
   end

   // result under construction
   logic [PW-1:0]            xe_ff, ye_ff;
   logic                     last_ff;
   logic [2*PW-1:0]          xsq_ff, ysq_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         xe_ff   <= xe;
         ye_ff   <= ye;
         last_ff <= last_pix;
      end
      if (state_ff == ST_SQUARE) begin
         xsq_ff <= (2*PW)'(xe_ff) * (2*PW)'(xe_ff);
         ysq_ff <= (2*PW)'(ye_ff) * (2*PW)'(ye_ff);
      end
   end

   // square root of the sum of squares
   logic                         root_done;
   logic [PW-1:0]                root;
   logic [sem_pkg::SQ_W-1:0]     sq_sum;

   assign sq_sum = sem_pkg::SQ_W'(xsq_ff) + sem_pkg::SQ_W'(ysq_ff);

   sem_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_START),
      .value (sq_sum),
      .done  (root_done),
      .root  (root)
   );

   // output register
   logic          rsp_valid_ff;
   logic [PW-1:0] rsp_x_ff, rsp_y_ff, rsp_mag_ff;
   logic          rsp_last_ff;
   logic          out_free, out_load;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign out_load = (state_ff == ST_ROOT) && root_done && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_x_ff    <= xe_ff;
         rsp_y_ff    <= ye_ff;
         rsp_mag_ff  <= root;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.x_edge     = rsp_x_ff;
   assign rsp_bus.y_edge     = rsp_y_ff;
   assign rsp_bus.magnitude  = rsp_mag_ff;
   assign rsp_bus.frame_last = rsp_last_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_READ;
         ST_READ:   state_in = interior ? ST_SQUARE : ST_IDLE;
         ST_SQUARE: state_in = ST_START;
         ST_START:  state_in = ST_ROOT;
         ST_ROOT:   if (out_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

`default_nettype wire

FILE: sv/sem_isqrt.sv
// Iterative integer square root, one result bit per cycle, saturated to 8 bits.
// Depends on sem_pkg for widths.
`default_nettype none

module sem_isqrt (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [sem_pkg::SQ_W-1:0]   value,
   output logic                            done,
   output logic [sem_pkg::PIX_W-1:0]       root
);

   localparam int BIT_W = $clog2(sem_pkg::ROOT_STEPS);

   logic [sem_pkg::SQ_W-1:0]   val_ff;
   logic [sem_pkg::PIX_W-1:0]  root_ff, root_in;
   logic [BIT_W-1:0]           bit_ff;
   logic                       run_ff, done_ff;
   logic [sem_pkg::PIX_W-1:0]  trial;
   logic [2*sem_pkg::PIX_W-1:0] trial_sq;

   // test the next root bit against the operand
   always_comb begin
      trial    = root_ff | (sem_pkg::PIX_W'(1) << bit_ff);
      trial_sq = (2*sem_pkg::PIX_W)'(trial) * (2*sem_pkg::PIX_W)'(trial);
      root_in  = ({1'b0, trial_sq} <= val_ff) ? trial : root_ff;
   end

   // control: run for one step per root bit, then hold done until next start
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         run_ff  <= 1'b1;
         done_ff <= 1'b0;
      end else if (run_ff && bit_ff == '0) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b1;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         val_ff  <= value;
         root_ff <= '0;
         bit_ff  <= BIT_W'(sem_pkg::ROOT_STEPS - 1);
      end else if (run_ff) begin
         root_ff <= root_in;
         bit_ff  <= bit_ff - BIT_W'(1);
      end
   end

   // any operand of 2^16 or more has a root above the pixel range
   assign done = done_ff;
   assign root = val_ff[sem_pkg::SQ_W-1] ? sem_pkg::PIX_MAX : root_ff;

endmodule

`default_nettype wire

FILE: sim/sobel_edge_magnitude_chk.sv
// Checker for the Sobel edge magnitude block: mirrors the frame state, predicts each result.
// Watches the request, result and csr channels; depends on sem_pkg and sem_req_if/sem_rsp_if.
`timescale 1ns / 100ps

module sobel_edge_magnitude_chk (
   input  wire logic                           clock,
   input  wire logic                           reset,
   sem_req_if                                  req_mon,
   sem_rsp_if                                  rsp_mon,
   input  wire logic                           csr_we,
   input  wire logic [sem_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sem_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                                  mismatch_count,
   output int                                  results_owed
);

   localparam int MAX_W = sem_pkg::MAX_WIDTH_DEFAULT;
   localparam int PW    = sem_pkg::PIX_W;

   typedef struct packed {
      logic [PW-1:0] x_edge;
      logic [PW-1:0] y_edge;
      logic [PW-1:0] magnitude;
      logic          frame_last;
   } edge_result_type;

   // mirrored block state
   logic [sem_pkg::WIDTH_REG_W-1:0]  width_reg;
   logic [sem_pkg::HEIGHT_REG_W-1:0] height_reg;
   logic [PW-1:0]                    row_above     [MAX_W];
   logic [PW-1:0]                    row_two_above [MAX_W];
   logic [PW-1:0]                    win           [6];
   int unsigned                      col_pos;
   int unsigned                      row_pos;

   edge_result_type expected_edges[$];
   int              results_seen;

   initial begin
      mismatch_count = 0;
      results_owed   = 0;
      results_seen   = 0;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("%0t ns  result %0d: %s", $time, results_seen, msg);
   endtask

   function automatic int unsigned clamp_pix(input int sum);
      if (sum < 0) return 0;
      if (sum > int'(sem_pkg::PIX_MAX)) return 32'(sem_pkg::PIX_MAX);
      return unsigned'(sum);
   endfunction

   // largest root whose square fits, capped at full scale
   function automatic int unsigned root_floor_sat(input int unsigned v);
      int unsigned r;
      r = 0;
      while (r < sem_pkg::PIX_MAX && (r + 1) * (r + 1) <= v) r++;
      return r;
   endfunction

   // advance the mirrored window by one pixel request, queue the result it yields
   function automatic void predict_edges(input logic [PW-1:0] pix);
      int unsigned     w, h, slot, xe, ye;
      int              top_px, mid_px, bot_px, l0, l1, l2, m0, m2, gx, gy;
      edge_result_type res;
      w = 32'(width_reg);
      if (w < sem_pkg::MIN_DIM) w = sem_pkg::MIN_DIM;
      if (w > MAX_W) w = MAX_W;
      h = 32'(height_reg);
      if (h < sem_pkg::MIN_DIM) h = sem_pkg::MIN_DIM;
      if (h > sem_pkg::HEIGHT_LIMIT) h = sem_pkg::HEIGHT_LIMIT;
      slot   = (col_pos < MAX_W) ? col_pos : MAX_W - 1;
      bot_px = int'(pix);
      mid_px = int'(row_above[slot]);
      top_px = int'(row_two_above[slot]);

      if (row_pos >= 2 && col_pos >= 2) begin
         l0 = int'(win[0]);
         l1 = int'(win[1]);
         l2 = int'(win[2]);
         m0 = int'(win[3]);
         m2 = int'(win[5]);
         gx = (l0 + 2 * l1 + l2) - (top_px + 2 * mid_px + bot_px);
         gy = (l2 + 2 * m2 + bot_px) - (l0 + 2 * m0 + top_px);
         xe = clamp_pix(gx);
         ye = clamp_pix(gy);
         res.x_edge     = xe[PW-1:0];
         res.y_edge     = ye[PW-1:0];
         res.magnitude  = PW'(root_floor_sat(xe * xe + ye * ye));
         res.frame_last = (row_pos == h - 1) && (col_pos == w - 1);
         expected_edges.push_back(res);
      end

      // shift the window left, store the column back
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top_px[PW-1:0];
      win[4] = mid_px[PW-1:0];
      win[5] = pix;
      row_two_above[slot] = mid_px[PW-1:0];
      row_above[slot]     = pix;

      // wrap column, then row
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endfunction

   always @(posedge clock) begin
      edge_result_type want;
      if (reset) begin
         width_reg  = sem_pkg::WIDTH_RESET;
         height_reg = sem_pkg::HEIGHT_RESET;
         for (int i = 0; i < 6; i++) win[i] = '0;
         col_pos = 0;
         row_pos = 0;
         expected_edges.delete();
      end else begin
         // compare a delivered result against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            results_seen++;
            if (expected_edges.size() == 0) begin
               report_mismatch("result arrived with no request owing one");
            end else begin
               want = expected_edges.pop_front();
               if (rsp_mon.x_edge !== want.x_edge)
                  report_mismatch($sformatf("x_edge got %0d expected %0d",
                                            rsp_mon.x_edge, want.x_edge));
               if (rsp_mon.y_edge !== want.y_edge)
                  report_mismatch($sformatf("y_edge got %0d expected %0d",
                                            rsp_mon.y_edge, want.y_edge));
               if (rsp_mon.magnitude !== want.magnitude)
                  report_mismatch($sformatf("magnitude got %0d expected %0d",
                                            rsp_mon.magnitude, want.magnitude));
               if (rsp_mon.frame_last !== want.frame_last)
                  report_mismatch($sformatf("frame_last got %b expected %b",
                                            rsp_mon.frame_last, want.frame_last));
            end
         end

         // apply register writes
         if (csr_we) begin
            if (csr_index == sem_pkg::CSR_IMAGE_WIDTH)
               width_reg = csr_wdata[sem_pkg::WIDTH_REG_W-1:0];
            else if (csr_index == sem_pkg::CSR_IMAGE_HEIGHT)
               height_reg = csr_wdata[sem_pkg::HEIGHT_REG_W-1:0];
         end

         if (req_mon.valid && req_mon.ready) predict_edges(req_mon.pixel);
      end
      results_owed = expected_edges.size();
   end

endmodule

FILE: sim/sobel_edge_magnitude_tb.sv
// Testbench top for the Sobel edge magnitude block: clock, reset, pixel frames and verdict.
// Instantiates the block beside sobel_edge_magnitude_chk; depends on sem_pkg and the channels.
`timescale 1ns / 100ps

module sobel_edge_magnitude_tb;

   localparam int CYCLE_LIMIT    = 3_000_000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int LONG_HOLD      = 400;
   localparam int RANDOM_TARGET  = 920;
   localparam int DIRECTED_COUNT = 27;
   localparam int PW             = sem_pkg::PIX_W;

   typedef enum int {PX_NOISE, PX_BINARY, PX_RAMP, PX_FLAT} pix_style_type;

   // three 3x3 frames: full-scale edge, negative x gradient, mid-range gradient
   localparam logic [PW-1:0] DIRECTED_PIX [DIRECTED_COUNT] = '{
      8'd255, 8'd0,   8'd0,
      8'd255, 8'd0,   8'd0,
      8'd255, 8'd255, 8'd0,
      8'd0,   8'd0,   8'd255,
      8'd0,   8'd0,   8'd255,
      8'd0,   8'd0,   8'd255,
      8'd20,  8'd10,  8'd0,
      8'd25,  8'd15,  8'd5,
      8'd30,  8'd20,  8'd10
   };

   logic                           clock;
   logic                           reset;
   logic                           csr_we;
   logic [sem_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [sem_pkg::CSR_DATA_W-1:0] csr_wdata;

   sem_req_if req_bus ();
   sem_rsp_if rsp_bus ();

   int          mismatch_count;
   int          results_owed;
   int unsigned cycles;
   bit          idle_on;
   bit          long_hold_req;
   int          pos_col, pos_row, eff_w, eff_h;
   int          ramp_base, ramp_dx, ramp_dy;
   int          pixels_sent;

   sobel_edge_magnitude dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sobel_edge_magnitude_chk chk (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // bound the run
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side: random stall bursts, a long hold-off on each request
   initial begin
      int held;
      rsp_bus.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (long_hold_req) begin
            rsp_bus.ready <= 1'b0;
            for (held = 0; held < LONG_HOLD; held++) @(posedge clock);
            long_hold_req = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // write one register, then drop the enable
   task automatic write_reg(input logic [sem_pkg::CSR_IDX_W-1:0] which,
                            input int unsigned value);
      int unsigned v;
      csr_we    <= 1'b1;
      csr_index <= which;
      csr_wdata <= value[sem_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (which == sem_pkg::CSR_IMAGE_WIDTH) begin
         v     = value[sem_pkg::WIDTH_REG_W-1:0];
         eff_w = (v < sem_pkg::MIN_DIM) ? sem_pkg::MIN_DIM
               : (v > sem_pkg::MAX_WIDTH_DEFAULT) ? sem_pkg::MAX_WIDTH_DEFAULT : v;
      end else begin
         v     = value[sem_pkg::HEIGHT_REG_W-1:0];
         eff_h = (v < sem_pkg::MIN_DIM) ? sem_pkg::MIN_DIM
               : (v > sem_pkg::HEIGHT_LIMIT) ? sem_pkg::HEIGHT_LIMIT : v;
      end
   endtask

   // offer one pixel request, hold it until taken, track the frame position
   task automatic send_pixel(input logic [PW-1:0] pix);
      bit took;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pixel <= pix;
      do begin
         @(negedge clock);
         took = req_bus.ready;
         @(posedge clock);
      end while (!took);
      pixels_sent++;
      if (pos_col + 1 >= eff_w) begin
         pos_col = 0;
         pos_row = (pos_row + 1 >= eff_h) ? 0 : pos_row + 1;
      end else begin
         pos_col++;
      end
   endtask

   // drop valid, wait for every owed result, then let the pipeline drain
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (results_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [PW-1:0] next_pixel(input pix_style_type style);
      int v;
      case (style)
         PX_BINARY: v = $urandom_range(0, 1) ? int'(sem_pkg::PIX_MAX) : 0;
         PX_RAMP:   v = ramp_base + pos_col * ramp_dx + pos_row * ramp_dy
                        + int'($urandom_range(0, 3));
         PX_FLAT:   v = ramp_base;
         default:   v = $urandom;
      endcase
      return v[PW-1:0];
   endfunction

   function automatic void new_ramp();
      ramp_base = $urandom_range(0, 255);
      ramp_dx   = int'($urandom_range(0, 80)) - 40;
      ramp_dy   = int'($urandom_range(0, 80)) - 40;
   endfunction

   // mostly usual sizes, sometimes below the legal range or a little larger
   function automatic int unsigned pick_dim(input int unsigned upper);
      case ($urandom_range(0, 7))
         0:       return $urandom_range(0, sem_pkg::MIN_DIM - 1);
         1:       return $urandom_range(upper + 1, upper + 4);
         default: return $urandom_range(sem_pkg::MIN_DIM, upper);
      endcase
   endfunction

   // send pixels until the position returns to the frame origin
   task automatic finish_frame(input pix_style_type style);
      do send_pixel(next_pixel(style)); while (pos_col != 0 || pos_row != 0);
   endtask

   initial begin
      pix_style_type style;
      int            phase_no;
      int            lead;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.pixel <= '0;
      csr_we        <= 1'b0;
      csr_index     <= sem_pkg::CSR_IMAGE_WIDTH;
      csr_wdata     <= '0;
      idle_on       = 1'b0;
      long_hold_req = 1'b0;
      pos_col       = 0;
      pos_row       = 0;
      eff_w         = sem_pkg::WIDTH_RESET;
      eff_h         = sem_pkg::HEIGHT_RESET;
      pixels_sent   = 0;
      new_ramp();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames: saturation, negative clamp, registers below range, mid-range root
      write_reg(sem_pkg::CSR_IMAGE_WIDTH, sem_pkg::MIN_DIM);
      write_reg(sem_pkg::CSR_IMAGE_HEIGHT, sem_pkg::MIN_DIM);
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         if (i == 9) begin
            settle();
            write_reg(sem_pkg::CSR_IMAGE_WIDTH, 1);
            write_reg(sem_pkg::CSR_IMAGE_HEIGHT, 2);
         end
         send_pixel(DIRECTED_PIX[i]);
      end

      // random small frames, with mid-frame shrinks and long hold-offs
      phase_no = 0;
      while (pixels_sent < DIRECTED_COUNT + RANDOM_TARGET) begin
         settle();
         idle_on = ($urandom_range(0, 3) != 0);
         style   = pix_style_type'($urandom_range(0, 3));
         new_ramp();
         if (phase_no == 1 || $urandom_range(0, 11) == 0) long_hold_req = 1'b1;
         if (phase_no % 4 == 1) begin
            // stop inside a row, narrow the frame below the current column, go on
            write_reg(sem_pkg::CSR_IMAGE_WIDTH, $urandom_range(6, 12));
            write_reg(sem_pkg::CSR_IMAGE_HEIGHT, $urandom_range(4, 8));
            lead = eff_w * int'($urandom_range(2, eff_h - 2))
                   + int'($urandom_range(3, eff_w - 1));
            repeat (lead) send_pixel(next_pixel(style));
            settle();
            write_reg(sem_pkg::CSR_IMAGE_WIDTH, $urandom_range(0, pos_col));
            if ($urandom_range(0, 1))
               write_reg(sem_pkg::CSR_IMAGE_HEIGHT, $urandom_range(0, pos_row));
            finish_frame(style);
         end else begin
            write_reg(sem_pkg::CSR_IMAGE_WIDTH, pick_dim(12));
            write_reg(sem_pkg::CSR_IMAGE_HEIGHT, pick_dim(8));
            repeat ($urandom_range(1, 3)) begin
               finish_frame(style);
               style = pix_style_type'($urandom_range(0, 3));
            end
         end
         phase_no++;
      end

      // closing stretch with no idling: height register below range, then a small frame
      settle();
      idle_on = 1'b0;
      write_reg(sem_pkg::CSR_IMAGE_WIDTH, 12);
      write_reg(sem_pkg::CSR_IMAGE_HEIGHT, 0);
      finish_frame(PX_BINARY);
      settle();
      write_reg(sem_pkg::CSR_IMAGE_WIDTH, 5);
      write_reg(sem_pkg::CSR_IMAGE_HEIGHT, 4);
      finish_frame(PX_NOISE);
      settle();

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
